// File: rtl/gdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_pkg: shared types for the genotype group dedup counter
// Item and result payloads, the beat that runs down the cell chain, and
// the configuration register indexes.
// ----------------------------------------------------------------------------
package gdc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SNPS_IN_USE = 2'd0,
    REG_SEX_IN_KEY  = 2'd1
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] SNPS_IN_USE_RESET = 5'd16;
  localparam logic [15:0]           COUNT_MAX         = 16'hFFFF;

  // one input item
  typedef struct packed {
    logic        eligible;
    logic        sex;
    logic [31:0] genotype_bits;
    logic [15:0] individual_id;
  } item_t;

  // one result item
  typedef struct packed {
    logic        skipped;
    logic        new_group;
    logic [5:0]  group_index;
    logic [15:0] group_count;
    logic [15:0] first_member;
    logic        table_full;
  } result_t;

  // control and result fields carried by a beat through the chain
  typedef struct packed {
    logic        vld;
    logic        skip;
    logic        done;
    logic        new_group;
    logic [15:0] count;
    logic [15:0] first;
  } beat_t;

endpackage

// File: rtl/gdc_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_key: key builder
// Masks the genotype bits to the SNPs in use and places the sex bit on
// top when X mode is set.
// ----------------------------------------------------------------------------
module gdc_key #(
  parameter int MAX_SNPS = 16
) (
  input  gdc_pkg::item_t         item,
  input  logic [4:0]             snps_in_use,
  input  logic                   sex_in_key,
  output logic [2*MAX_SNPS:0]    key
);

  logic [4:0]  snps_eff;
  logic [63:0] geno_ext;

  // clamp the snp count to the key size
  assign snps_eff = (snps_in_use > 5'(MAX_SNPS)) ? 5'(MAX_SNPS) : snps_in_use;
  assign geno_ext = 64'(item.genotype_bits);

  // keep only bits of snps below the clamped count
  always_comb begin
    for (int b = 0; b < 2 * MAX_SNPS; b++) begin
      key[b] = geno_ext[b] && ((b >> 1) < int'(snps_eff));
    end
    key[2*MAX_SNPS] = sex_in_key && item.sex;
  end

endmodule

// File: rtl/gdc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_cell: one group slot of the chain
// Holds one group's key, count and reference member, checks the passing
// beat against it, claims an empty slot on a miss and forwards the beat.
// ----------------------------------------------------------------------------
module gdc_cell #(
  parameter int KEY_W    = 33,
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gdc_pkg::beat_t       fwd_beat,
  input  logic [KEY_W-1:0]     fwd_key,
  input  logic [15:0]          fwd_id,
  input  logic [IDX_W-1:0]     fwd_idx,
  output gdc_pkg::beat_t       pass_beat,
  output logic [KEY_W-1:0]     pass_key,
  output logic [15:0]          pass_id,
  output logic [IDX_W-1:0]     pass_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic             valid;
  logic [KEY_W-1:0] key;
  logic [15:0]      count;
  logic [15:0]      ref_id;

  logic             live;
  logic             hit;
  logic             claim;
  logic [15:0]      count_next;
  gdc_pkg::beat_t   beat_next;
  logic [IDX_W-1:0] idx_next;

  // match or claim decision for a beat not yet resolved upstream
  assign live  = fwd_beat.vld && !fwd_beat.skip && !fwd_beat.done;
  assign hit   = live && valid && (key == fwd_key);
  assign claim = live && !valid;
  assign count_next = (count == gdc_pkg::COUNT_MAX) ? count : count + 16'd1;

  // update the beat with this slot's answer
  always_comb begin
    beat_next = fwd_beat;
    idx_next  = fwd_idx;
    if (hit) begin
      beat_next.done  = 1'b1;
      beat_next.count = count_next;
      beat_next.first = ref_id;
      idx_next        = MY_IDX;
    end else if (claim) begin
      beat_next.done      = 1'b1;
      beat_next.new_group = 1'b1;
      beat_next.count     = 16'd1;
      beat_next.first     = fwd_id;
      idx_next            = MY_IDX;
    end
  end

  // slot occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (claim) begin
      valid <= 1'b1;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (claim) begin
      key    <= fwd_key;
      count  <= 16'd1;
      ref_id <= fwd_id;
    end else if (hit) begin
      count <= count_next;
    end
  end

  // beat register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_beat.vld <= 1'b0;
    end else begin
      pass_beat.vld <= beat_next.vld;
    end
    pass_beat.skip      <= beat_next.skip;
    pass_beat.done      <= beat_next.done;
    pass_beat.new_group <= beat_next.new_group;
    pass_beat.count     <= beat_next.count;
    pass_beat.first     <= beat_next.first;
    pass_key            <= fwd_key;
    pass_id             <= fwd_id;
    pass_idx            <= idx_next;
  end

endmodule

// File: rtl/genotype_group_dedup_counter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// genotype_group_dedup_counter_top: distinct genotype group counter
// Counts individuals per distinct multilocus genotype key in a chain of
// group slots, one slot per cell.
// ----------------------------------------------------------------------------
// An item is taken in every cycle in which start is high; busy is high only
// while rst is held. Each beat walks the chain of MAX_GROUPS cells, one cell
// per cycle, and its result is registered after the last cell and appears on
// the result port with strobe high for a single cycle. Results come out in
// the order the items went in and must be taken when strobed, since the
// receiver cannot hold them off. A beat that follows another with the same
// key sees the slot the earlier one created or bumped, because it reaches
// each cell only after the earlier beat has left it. Groups are cleared at
// once by rst. Configuration writes take effect on the next item; the user
// must make them while no beat is in the chain, the block does not enforce it.
// ----------------------------------------------------------------------------
module genotype_group_dedup_counter_top #(
  parameter int MAX_SNPS   = 16,
  parameter int MAX_GROUPS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  gdc_pkg::item_t                 item,
  output logic                           strobe,
  output gdc_pkg::result_t               result,
  input  logic                           cfg_we,
  input  logic [gdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gdc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int KEY_W = 2 * MAX_SNPS + 1;
  localparam int IDX_W = $clog2(MAX_GROUPS);

  logic [4:0]       snps_in_use;
  logic             sex_in_key;

  gdc_pkg::beat_t   head;
  gdc_pkg::beat_t   beat     [0:MAX_GROUPS];
  logic [KEY_W-1:0] beat_key [0:MAX_GROUPS];
  logic [15:0]      beat_id  [0:MAX_GROUPS];
  logic [IDX_W-1:0] beat_idx [0:MAX_GROUPS];

  gdc_pkg::beat_t   tail;
  logic [31:0]      tail_idx;

  assign busy = rst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      snps_in_use <= gdc_pkg::SNPS_IN_USE_RESET;
      sex_in_key  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gdc_pkg::REG_SNPS_IN_USE: snps_in_use <= cfg_data[4:0];
        gdc_pkg::REG_SEX_IN_KEY:  sex_in_key  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // head of the chain: build the key and an unresolved beat
  gdc_key #(
    .MAX_SNPS(MAX_SNPS)
  ) u_key (
    .item       (item),
    .snps_in_use(snps_in_use),
    .sex_in_key (sex_in_key),
    .key        (beat_key[0])
  );

  always_comb begin
    head      = '0;
    head.vld  = start && !busy;
    head.skip = !item.eligible;
  end
  assign beat[0]     = head;
  assign beat_id[0]  = item.individual_id;
  assign beat_idx[0] = '0;

  // chain of group slots
  for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_cell
    gdc_cell #(
      .KEY_W   (KEY_W),
      .IDX_W   (IDX_W),
      .CELL_IDX(g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .fwd_beat (beat[g]),
      .fwd_key  (beat_key[g]),
      .fwd_id   (beat_id[g]),
      .fwd_idx  (beat_idx[g]),
      .pass_beat(beat[g+1]),
      .pass_key (beat_key[g+1]),
      .pass_id  (beat_id[g+1]),
      .pass_idx (beat_idx[g+1])
    );
  end

  // tail: end of the chain; an unresolved eligible beat here found no free slot
  assign tail     = beat[MAX_GROUPS];
  assign tail_idx = 32'(beat_idx[MAX_GROUPS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= tail.vld;
    end
  end

  always_ff @(posedge clk) begin
    result.skipped      <= tail.skip;
    result.new_group    <= tail.new_group;
    result.group_index  <= tail_idx[5:0];
    result.group_count  <= tail.count;
    result.first_member <= tail.first;
    result.table_full   <= !tail.skip && !tail.done;
  end

endmodule

// File: rtl/gdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_checker: port-level checks for the group counter
// Watches the item and result ports for latency and result consistency.
// ----------------------------------------------------------------------------
module gdc_checker #(
  parameter int MAX_GROUPS = 64
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             strobe,
  input gdc_pkg::result_t result
);

  localparam int LAT = MAX_GROUPS + 1;

  // every accepted item gives a result after the chain latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT strobe)
    else $error("accepted item gave no result after chain latency");

  // no result without an item taken the chain latency earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, LAT))
    else $error("result strobed with no matching item");

  // a result is at most one of skipped, new group, table full
  a_outcome: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $onehot0({result.skipped, result.new_group, result.table_full}))
    else $error("result outcome flags overlap");

  // resolved results carry a nonzero count, others carry none
  a_count: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((result.skipped || result.table_full) ?
                (result.group_count == 16'd0 && result.first_member == 16'd0) :
                (result.group_count != 16'd0)))
    else $error("group count inconsistent with outcome");

endmodule

bind genotype_group_dedup_counter_top gdc_checker #(
  .MAX_GROUPS(MAX_GROUPS)
) u_gdc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .strobe(strobe),
  .result(result)
);
